/* rtl/flog_pkg.sv */
// flog_pkg: constants, series coefficients and arithmetic helpers for the
// fixed point log unit; no dependencies
`default_nettype none

package flog_pkg;

    // number format
    localparam int FRAC   = 16;
    localparam int XW     = 32;
    localparam int KW     = 5;
    localparam logic [XW-1:0] FX_ONE = XW'(64'd1 << FRAC);
    localparam logic [XW-1:0] FX_TWO = XW'(64'd2 << FRAC);

    // divider geometry: dividend is a word shifted up by the fraction
    localparam int DVD_W     = XW + FRAC;
    localparam int DVS_W     = XW;
    localparam int DIV_STEPS = DVD_W;

    // latency of the log pipeline and of the whole unit
    localparam int LN_LAT  = DIV_STEPS + 11;
    localparam int TOT_LAT = LN_LAT + DIV_STEPS + 2;

    // series coefficients and ln2, rounded from 2^-32 units to the fraction
    localparam logic [63:0] RND = 64'd1 << (31 - FRAC);
    localparam logic [XW-1:0] LG0 = XW'((64'd2863311531 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG1 = XW'((64'd1717986918 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG2 = XW'((64'd1227133521 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG3 = XW'((64'd954436155 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG4 = XW'((64'd780978478 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG5 = XW'((64'd657724321 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LG6 = XW'((64'd635577251 + RND) >> (32 - FRAC));
    localparam logic [XW-1:0] LN2 = XW'((64'd2977044472 + RND) >> (32 - FRAC));

    // fixed point product, arithmetic shift and wrap to a word
    function automatic logic [XW-1:0] fx_mul(input logic signed [XW-1:0] a,
                                             input logic signed [XW-1:0] b);
        logic signed [2*XW-1:0] p;
        p = a * b;
        return p[FRAC+XW-1:FRAC];
    endfunction

    // magnitude of a signed word as an unsigned word
    function automatic logic [XW-1:0] fx_abs(input logic [XW-1:0] a);
        return a[XW-1] ? XW'(-a) : a;
    endfunction

endpackage

`default_nettype wire

/* rtl/flog_div.sv */
// flog_div: pipelined restoring divider, one quotient bit per stage,
// unsigned magnitudes; depends on flog_pkg
`default_nettype none

module flog_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [flog_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [flog_pkg::DVS_W-1:0]  i_divisor,
    output logic      [flog_pkg::DVD_W-1:0]  o_quotient
);
    import flog_pkg::*;

    logic [DVS_W-1:0] r_rem [DIV_STEPS];
    logic [DVD_W-1:0] r_dq  [DIV_STEPS];
    logic [DVS_W-1:0] r_dvs [DIV_STEPS];

    // one shift and trial subtract per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [DVS_W-1:0] p_rem;
        logic [DVD_W-1:0] p_dq;
        logic [DVS_W-1:0] p_dvs;
        logic [DVS_W:0]   trial;
        logic             ge;

        if (j == 0) begin : g_first
            assign p_rem = '0;
            assign p_dq  = i_dividend;
            assign p_dvs = i_divisor;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_dq  = r_dq[j-1];
            assign p_dvs = r_dvs[j-1];
        end

        assign trial = {p_rem, p_dq[DVD_W-1]};
        assign ge    = trial >= {1'b0, p_dvs};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? DVS_W'(trial - {1'b0, p_dvs}) : DVS_W'(trial);
                r_dq[j]  <= {p_dq[DVD_W-2:0], ge};
                r_dvs[j] <= p_dvs;
            end
        end
    end

    assign o_quotient = r_dq[DIV_STEPS-1];

endmodule

`default_nettype wire

/* rtl/flog_ln.sv */
// flog_ln: pipelined fixed point natural logarithm (range reduction,
// divider for s, series in z); depends on flog_pkg and flog_div
`default_nettype none

module flog_ln (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [flog_pkg::XW-1:0] i_x,
    output logic      [flog_pkg::XW-1:0] o_ln
);
    import flog_pkg::*;

    typedef struct packed {
        logic [XW-1:0] f;
        logic [KW-1:0] k;
        logic          fneg;
        logic          neg;
        logic          zero;
    } t_side;

    // stage a: halving count and special cases
    logic [XW-1:0] r_a_x;
    logic [KW-1:0] r_a_k;
    logic          r_a_neg;
    logic          r_a_zero;
    logic [KW-1:0] n_k;

    always_comb begin
        n_k = KW'(XW - 2);
        for (int j = XW - 2; j >= 0; j--) begin
            if ((i_x >> j) <= FX_TWO) n_k = KW'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_k    <= n_k;
            r_a_neg  <= i_x[XW-1];
            r_a_zero <= (i_x == '0);
        end
    end

    // stage b: reduced argument and divider operands
    logic [XW-1:0]    n_xi, n_f;
    logic [DVD_W-1:0] r_b_dvd;
    logic [DVS_W-1:0] r_b_dvs;
    t_side            r_b_side;

    assign n_xi = r_a_x >> r_a_k;
    assign n_f  = n_xi - FX_ONE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_dvd       <= DVD_W'(fx_abs(n_f)) << FRAC;
            r_b_dvs       <= DVS_W'(n_f + FX_TWO);
            r_b_side.f    <= n_f;
            r_b_side.k    <= r_a_k;
            r_b_side.fneg <= n_f[XW-1];
            r_b_side.neg  <= r_a_neg;
            r_b_side.zero <= r_a_zero;
        end
    end

    // s = f / (2 + f)
    logic [DVD_W-1:0] quot;

    flog_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_b_dvd),
        .i_divisor  (r_b_dvs),
        .o_quotient (quot)
    );

    // side data along the divider
    t_side r_dly [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r_b_side;
            for (int j = 1; j < DIV_STEPS; j++) r_dly[j] <= r_dly[j-1];
        end
    end

    // series stages
    t_side         r_sd [8];
    logic [XW-1:0] r_s  [7];
    logic [XW-1:0] r_z  [5];
    logic [XW-1:0] r_w  [2:4];
    logic [XW-1:0] r_pa, r_pb, r_pa2, r_pb2, r_t1, r_t1d, r_pb3, r_t2;
    logic [XW-1:0] r_u, r_kl, r_ln;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // signed s
            r_sd[0] <= r_dly[DIV_STEPS-1];
            r_s[0]  <= r_dly[DIV_STEPS-1].fneg ? XW'(-quot[XW-1:0]) : quot[XW-1:0];
            for (int j = 1; j < 8; j++) r_sd[j] <= r_sd[j-1];
            for (int j = 1; j < 7; j++) r_s[j] <= r_s[j-1];
            // z and w
            r_z[0] <= fx_mul(r_s[0], r_s[0]);
            for (int j = 1; j < 5; j++) r_z[j] <= r_z[j-1];
            r_w[2] <= fx_mul(r_z[0], r_z[0]);
            for (int j = 3; j < 5; j++) r_w[j] <= r_w[j-1];
            // two interleaved horner chains in w
            r_pa  <= fx_mul(r_w[2], LG5);
            r_pb  <= fx_mul(r_w[2], LG6);
            r_pa2 <= fx_mul(r_w[3], LG3 + r_pa);
            r_pb2 <= fx_mul(r_w[3], LG4 + r_pb);
            r_t1  <= fx_mul(r_w[4], LG1 + r_pa2);
            r_pb3 <= fx_mul(r_w[4], LG2 + r_pb2);
            r_t2  <= fx_mul(r_z[4], LG0 + r_pb3);
            r_t1d <= r_t1;
            // s * (f - r) and k * ln2
            r_u  <= fx_mul(r_s[6], r_sd[6].f - (r_t1d + r_t2));
            r_kl <= XW'(r_sd[6].k * LN2);
            // final sum with special cases
            if (r_sd[7].neg) begin
                r_ln <= '0;
            end else if (r_sd[7].zero) begin
                r_ln <= '1;
            end else begin
                r_ln <= r_kl + r_sd[7].f - r_u;
            end
        end
    end

    assign o_ln = r_ln;

endmodule

`default_nettype wire

/* rtl/fixed_point_log_unit_core.sv */
// fixed_point_log_unit_core: top level, natural or configured base log per item
// depends on flog_pkg, flog_ln, flog_div
//
//   port group    dir  contents
//   i_s_*         in   tdata: x_value[31:0]; tuser: mode
//   o_m_*         out  tdata: log_result[31:0]; tuser: divide_fault
//   i_cfg_*       in   log_base[30:0], written when i_cfg_we is high
//
// one item per cycle unless the output stalls; the pipeline holds two 48-step divider chains
// (the s quotient inside the log and the base quotient after it)
// synchronous active low reset clears valid bits and sets log_base to 10.0
// a stalled output holds the whole pipeline; nothing is dropped or repeated
`default_nettype none

module fixed_point_log_unit_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // x_value[31:0]
    input  wire logic        i_s_tuser,   // mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // log_result[31:0]
    output logic             o_m_tuser,   // divide_fault
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata
);
    import flog_pkg::*;

    typedef struct packed {
        logic          mode;
        logic          fault;
        logic          qneg;
        logic [XW-1:0] res;
    } t_fin;

    logic en;
    logic r_vld [TOT_LAT];
    logic r_md  [LN_LAT];
    logic [30:0] r_log_base;

    assign en         = !r_vld[TOT_LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[TOT_LAT-1];

    // base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_base <= 31'd655360;
        end else if (i_cfg_we) begin
            r_log_base <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TOT_LAT; j++) r_vld[j] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int j = 1; j < TOT_LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // mode along the log pipelines
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[0] <= i_s_tuser;
            for (int j = 1; j < LN_LAT; j++) r_md[j] <= r_md[j-1];
        end
    end

    // logs of the argument and of the base, in step
    logic [XW-1:0] ln_x, ln_b;

    flog_ln u_ln_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_s_tdata),
        .o_ln  (ln_x)
    );

    flog_ln u_ln_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ({1'b0, r_log_base}),
        .o_ln  (ln_b)
    );

    // quotient operands
    logic [DVD_W-1:0] r_p_dvd;
    logic [DVS_W-1:0] r_p_dvs;
    t_fin             r_p_fin;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dvd       <= DVD_W'(fx_abs(ln_x)) << FRAC;
            r_p_dvs       <= fx_abs(ln_b);
            r_p_fin.mode  <= r_md[LN_LAT-1];
            r_p_fin.fault <= r_md[LN_LAT-1] && (ln_b == '0);
            r_p_fin.qneg  <= ln_x[XW-1] ^ ln_b[XW-1];
            r_p_fin.res   <= ln_x;
        end
    end

    logic [DVD_W-1:0] quot;

    flog_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_p_dvd),
        .i_divisor  (r_p_dvs),
        .o_quotient (quot)
    );

    t_fin r_fd [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fd[0] <= r_p_fin;
            for (int j = 1; j < DIV_STEPS; j++) r_fd[j] <= r_fd[j-1];
        end
    end

    // output register
    t_fin          fin;
    logic [XW-1:0] r_out;
    logic          r_fault;
    logic          r_omode;

    assign fin = r_fd[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_omode <= fin.mode;
            if (!fin.mode) begin
                r_out   <= fin.res;
                r_fault <= 1'b0;
            end else if (fin.fault) begin
                r_out   <= '0;
                r_fault <= 1'b1;
            end else begin
                r_out   <= fin.qneg ? XW'(-quot[XW-1:0]) : quot[XW-1:0];
                r_fault <= 1'b0;
            end
        end
    end

    assign o_m_tdata = r_out;
    assign o_m_tuser = r_fault;

    // checks
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("fault item with nonzero result");

    a_fault_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> r_omode)
        else $error("fault flagged on a natural log item");

    a_prep_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_fin.fault |-> r_p_fin.mode && r_p_dvs == '0)
        else $error("zero divisor flag inconsistent");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
